>>> hdl/char_lcd_controller_write_defines.svh
// assertion macros for the character lcd controller
`ifndef CHAR_LCD_CONTROLLER_WRITE_DEFINES_SVH
`define CHAR_LCD_CONTROLLER_WRITE_DEFINES_SVH

// same-cycle implication, checked on clk with rst masking
`define CLW_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("char lcd controller check failed");

// next-cycle implication, checked on clk with rst masking
`define CLW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("char lcd controller check failed");

`endif

>>> hdl/clcdw_pkg.sv
// types, sizes and command codes of the character lcd controller
package clcdw_pkg;

  // store sizes
  localparam int DISPLAY_CELLS = 80;
  localparam int LINE_CELLS    = 40;
  localparam int GLYPH_ROWS    = 64;
  localparam int DISP_AW       = $clog2(DISPLAY_CELLS);

  localparam logic [7:0] DISP_LIMIT = 8'(DISPLAY_CELLS);
  localparam logic [7:0] LINE_OFS   = 8'(LINE_CELLS);
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // item modes
  localparam logic [1:0] MODE_CMD      = 2'd0;
  localparam logic [1:0] MODE_DATA     = 2'd1;
  localparam logic [1:0] MODE_RD_DISP  = 2'd2;
  localparam logic [1:0] MODE_RD_GLYPH = 2'd3;

  // bit positions in the mode flags
  localparam int FL_BLINK   = 0;
  localparam int FL_CURSOR  = 1;
  localparam int FL_DISPLAY = 2;
  localparam int FL_FONT    = 3;
  localparam int FL_TWOLINE = 4;
  localparam int FL_WIDE    = 5;
  localparam int FL_SHIFT   = 6;
  localparam int FL_INC     = 7;

  // command patterns and masks
  localparam logic [7:0] CMD_FUNC_MASK   = 8'he0;
  localparam logic [7:0] CMD_FUNC        = 8'h20;
  localparam logic [7:0] CMD_DISP_MASK   = 8'hf8;
  localparam logic [7:0] CMD_DISP        = 8'h08;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME_MASK   = 8'hfe;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MASK  = 8'hfc;
  localparam logic [7:0] CMD_ENTRY       = 8'h04;
  localparam logic [7:0] CMD_CGADDR_MASK = 8'hc0;
  localparam logic [7:0] CMD_CGADDR      = 8'h40;
  localparam logic [7:0] CMD_DDADDR_MASK = 8'h80;
  localparam logic [7:0] CMD_DDADDR      = 8'h80;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic [6:0] read_index;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] ddram_addr;
    logic [5:0] cgram_addr;
    logic       data_to_display;
    logic       display_on;
    logic       cursor_on;
    logic       blink_on;
    logic       two_line;
    logic       increment_mode;
    logic       shift_on;
    logic       wide_bus;
    logic       tall_font;
  } lcd_rsp_t;

endpackage

>>> hdl/char_lcd_controller_write.sv
// character lcd controller: command, data and read port over two storage rams
// the result passes the registered ram read and then the output register
// a new item is taken only once the previous result has been taken, as the block
//   steps through its read and hold states with a single output register
// reset: addresses, flags and target clear; per-entry valid bits clear so the
//   display store reads as spaces and the glyph store as zero, with no sweep
`include "char_lcd_controller_write_defines.svh"

module char_lcd_controller_write import clcdw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lcd_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lcd_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;

  state_t state;

  // status registers
  logic [6:0] disp_addr, disp_addr_next;
  logic [5:0] glyph_addr, glyph_addr_next;
  logic       target, target_next;
  logic [7:0] flags, flags_next;

  // storage and per-entry valid bits
  logic [7:0]               disp_mem [DISPLAY_CELLS];
  logic [4:0]               glyph_mem [GLYPH_ROWS];
  logic [DISPLAY_CELLS-1:0] disp_vld;
  logic [GLYPH_ROWS-1:0]    glyph_vld;

  // write controls
  logic               accept;
  logic               up;
  logic               clear_all;
  logic               disp_we;
  logic               glyph_we;
  logic [7:0]         col;
  logic [7:0]         cell_pos;
  logic [7:0]         cell_sel;
  logic               cell_ok;
  logic [DISP_AW-1:0] disp_wa;

  // registered read side
  logic [7:0] disp_rd;
  logic [4:0] glyph_rd;
  logic       disp_vld_rd;
  logic       glyph_vld_rd;
  logic [1:0] rd_mode;
  logic       rd_ok;
  lcd_rsp_t   rsp_next;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign up        = flags[FL_INC];

  // display cell for a data write at the current address
  always_comb begin
    col      = {2'b00, disp_addr[5:0]};
    cell_pos = col + (disp_addr[6] ? LINE_OFS : 8'd0);
    if (flags[FL_TWOLINE]) begin
      cell_sel = cell_pos;
      cell_ok  = (col < LINE_OFS) && (cell_pos < DISP_LIMIT);
    end else begin
      cell_sel = {1'b0, disp_addr};
      cell_ok  = ({1'b0, disp_addr} < DISP_LIMIT);
    end
    disp_wa  = cell_sel[DISP_AW-1:0];
  end

  // command decode and data write update
  always_comb begin
    disp_addr_next  = disp_addr;
    glyph_addr_next = glyph_addr;
    target_next     = target;
    flags_next      = flags;
    clear_all       = 1'b0;
    disp_we         = 1'b0;
    glyph_we        = 1'b0;
    if (accept) begin
      case (req.mode)
        MODE_CMD: begin
          if ((req.data & CMD_FUNC_MASK) == CMD_FUNC) begin
            flags_next[FL_WIDE]    = req.data[4];
            flags_next[FL_TWOLINE] = req.data[3];
            flags_next[FL_FONT]    = req.data[2];
          end else if ((req.data & CMD_DISP_MASK) == CMD_DISP) begin
            flags_next[FL_DISPLAY] = req.data[2];
            flags_next[FL_CURSOR]  = req.data[1];
            flags_next[FL_BLINK]   = req.data[0];
          end else if (req.data == CMD_CLEAR) begin
            disp_addr_next     = 7'd0;
            flags_next[FL_INC] = 1'b1;
            clear_all          = 1'b1;
          end else if ((req.data & CMD_HOME_MASK) == CMD_HOME) begin
            disp_addr_next = 7'd0;
          end else if ((req.data & CMD_ENTRY_MASK) == CMD_ENTRY) begin
            flags_next[FL_INC]   = req.data[1];
            flags_next[FL_SHIFT] = req.data[0];
          end else if ((req.data & CMD_CGADDR_MASK) == CMD_CGADDR) begin
            glyph_addr_next = req.data[5:0];
            target_next     = 1'b0;
          end else if ((req.data & CMD_DDADDR_MASK) == CMD_DDADDR) begin
            disp_addr_next = req.data[6:0];
            target_next    = 1'b1;
          end
        end
        MODE_DATA: begin
          if (!target) begin
            glyph_we        = 1'b1;
            glyph_addr_next = up ? glyph_addr + 6'd1 : glyph_addr - 6'd1;
          end else begin
            disp_we        = cell_ok;
            disp_addr_next = up ? disp_addr + 7'd1 : disp_addr - 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_addr  <= 7'd0;
      glyph_addr <= 6'd0;
      target     <= 1'b0;
      flags      <= 8'd0;
    end else begin
      disp_addr  <= disp_addr_next;
      glyph_addr <= glyph_addr_next;
      target     <= target_next;
      flags      <= flags_next;
    end
  end

  // valid bits: a clear command empties the display store at once
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_vld  <= '0;
      glyph_vld <= '0;
    end else begin
      if (clear_all) begin
        disp_vld <= '0;
      end else if (disp_we) begin
        disp_vld[disp_wa] <= 1'b1;
      end
      if (glyph_we) begin
        glyph_vld[glyph_addr] <= 1'b1;
      end
    end
  end

  // display ram
  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[disp_wa] <= req.data;
    end
    if (accept) begin
      disp_rd <= disp_mem[req.read_index[DISP_AW-1:0]];
    end
  end

  // glyph ram
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_addr] <= req.data[4:0];
    end
    if (accept) begin
      glyph_rd <= glyph_mem[req.read_index[5:0]];
    end
  end

  // read qualifiers captured with the ram read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mode      <= req.mode;
      disp_vld_rd  <= disp_vld[req.read_index[DISP_AW-1:0]];
      glyph_vld_rd <= glyph_vld[req.read_index[5:0]];
      if (req.mode == MODE_RD_DISP) begin
        rd_ok <= ({1'b0, req.read_index} < DISP_LIMIT);
      end else begin
        rd_ok <= !req.read_index[6];
      end
    end
  end

  // result assembly
  always_comb begin
    rsp_next.read_data = 8'd0;
    if (rd_ok && (rd_mode == MODE_RD_DISP)) begin
      rsp_next.read_data = disp_vld_rd ? disp_rd : SPACE_CHAR;
    end else if (rd_ok && (rd_mode == MODE_RD_GLYPH)) begin
      rsp_next.read_data = {3'b000, (glyph_vld_rd ? glyph_rd : 5'd0)};
    end
    rsp_next.ddram_addr      = disp_addr;
    rsp_next.cgram_addr      = glyph_addr;
    rsp_next.data_to_display = target;
    rsp_next.display_on      = flags[FL_DISPLAY];
    rsp_next.cursor_on       = flags[FL_CURSOR];
    rsp_next.blink_on        = flags[FL_BLINK];
    rsp_next.two_line        = flags[FL_TWOLINE];
    rsp_next.increment_mode  = flags[FL_INC];
    rsp_next.shift_on        = flags[FL_SHIFT];
    rsp_next.wide_bus        = flags[FL_WIDE];
    rsp_next.tall_font       = flags[FL_FONT];
  end

  // item sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          rsp       <= rsp_next;
          rsp_valid <= 1'b1;
          state     <= S_HOLD;
        end
        S_HOLD: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CLW_ASSERT_NOW(a_one_item, rsp_valid, !req_ready)
  `CLW_ASSERT_NEXT(a_accept_busy, accept, !req_ready && !rsp_valid)
  `CLW_ASSERT_NEXT(a_clear_home, clear_all, (disp_addr == 7'd0) && flags[FL_INC] && (disp_vld == '0))
  `CLW_ASSERT_NEXT(a_read_keeps, accept && req.mode[1], $stable(disp_addr) && $stable(glyph_addr) && $stable(flags) && $stable(target))

endmodule
